// ===== sv/two_hash_probing_id_table_macros.svh =====
// Assertion helpers for the ID table checker.
// All properties sample on the rising edge of clk and are disabled in reset.
`ifndef TWO_HASH_PROBING_ID_TABLE_MACROS_SVH
`define TWO_HASH_PROBING_ID_TABLE_MACROS_SVH

// same-cycle implication
`define THP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define THP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/thp_pkg.sv =====
package thp_pkg;

  localparam int unsigned SLOT_COUNT   = 256;
  localparam int unsigned PROBE_ROUNDS = 16;

  localparam int unsigned HASH_PRIME   = 104729;
  localparam int unsigned HASH_MUL_ONE = 853;
  localparam int unsigned HASH_MUL_TWO = 1734;

  localparam int ID_W         = 31;
  localparam int KEY_W        = 32;
  localparam int SLOT_FIELD_W = 8;
  localparam int STATUS_W     = 3;

  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int ROUND_BITS = (PROBE_ROUNDS > 1) ? $clog2(PROBE_ROUNDS) : 1;
  localparam int SLOT_EXT_W = (SLOT_BITS > SLOT_FIELD_W) ? SLOT_BITS : SLOT_FIELD_W;

  // remainder unit covers both divisors it is used with
  localparam int unsigned REM_MAX = (HASH_PRIME > SLOT_COUNT) ? HASH_PRIME : SLOT_COUNT;
  localparam int REM_W = $clog2(REM_MAX + 1);

  // reciprocals: q = (x * RECIP) >> SHIFT is exact while x * (RECIP * d - 2^SHIFT) < 2^SHIFT
  localparam int              RP_SHIFT  = ID_W + $clog2(HASH_PRIME);
  localparam longint unsigned RECIP_P   = ((64'd1 << RP_SHIFT) + HASH_PRIME - 1) / HASH_PRIME;
  localparam int              RECIP_P_W = $clog2(RECIP_P + 1);
  localparam int              QP_W      = ID_W + RECIP_P_W - RP_SHIFT;

  localparam int              RT_SHIFT  = REM_W + SLOT_BITS;
  localparam longint unsigned RECIP_T   = ((64'd1 << RT_SHIFT) + SLOT_COUNT - 1) / SLOT_COUNT;
  localparam int              RECIP_T_W = $clog2(RECIP_T + 1);
  localparam int              QT_W      = REM_W + RECIP_T_W - RT_SHIFT;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_NEW         = 3'd0;
  localparam status_t ST_REACTIVATED = 3'd1;
  localparam status_t ST_ACTIVE      = 3'd2;
  localparam status_t ST_FULL        = 3'd3;
  localparam status_t ST_REMOVED     = 3'd4;
  localparam status_t ST_NOT_FOUND   = 3'd5;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;

  typedef struct packed {
    logic            active;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic            start;
    logic [ID_W-1:0] key;
  } rem_req_t;

  typedef struct packed {
    logic             done;
    logic [REM_W-1:0] rem;
    slot_idx_t        slot_rem;
  } rem_rsp_t;

  typedef slot_idx_t hash_tab_t [SLOT_COUNT];

  // Slot for a reduced key m = (k mod prime) mod slots; evaluated at elaboration only.
  function automatic hash_tab_t build_hash_tab(int unsigned mul, int unsigned add);
    hash_tab_t   tab;
    int unsigned v;
    for (int unsigned m = 0; m < SLOT_COUNT; m++) begin
      v = ((m * mul + add) % HASH_PRIME) % SLOT_COUNT;
      tab[m] = SLOT_BITS'(v);
    end
    return tab;
  endfunction

  localparam hash_tab_t HASH_ONE_TAB = build_hash_tab(HASH_MUL_ONE, HASH_MUL_TWO);
  localparam hash_tab_t HASH_TWO_TAB = build_hash_tab(HASH_MUL_TWO, HASH_MUL_ONE);

endpackage

// ===== sv/thp_ram.sv =====
module thp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/thp_rem.sv =====
// Key mod prime, then that mod slot count, by reciprocal multiplication.
// Registered in order: key, prod_p, rem_p, prod_t, rem_t, then done.
module thp_rem (
  input  logic              clk,
  input  logic              rst,
  input  thp_pkg::rem_req_t req,
  output thp_pkg::rem_rsp_t rsp
);
  import thp_pkg::*;

  localparam int PP_W = ID_W + RECIP_P_W;
  localparam int PT_W = REM_W + RECIP_T_W;

  localparam logic [RECIP_P_W-1:0] RECIP_P_V = RECIP_P_W'(RECIP_P);
  localparam logic [RECIP_T_W-1:0] RECIP_T_V = RECIP_T_W'(RECIP_T);

  logic [3:0]       vld;
  logic             done;
  logic [ID_W-1:0]  key;
  logic [PP_W-1:0]  prod_p;
  logic [QP_W-1:0]  qp;
  logic [KEY_W-1:0] qp_mul;
  logic [KEY_W-1:0] diff_p;
  logic [REM_W-1:0] rem_p;
  logic [PT_W-1:0]  prod_t;
  logic [QT_W-1:0]  qt;
  logic [REM_W-1:0] qt_mul;
  logic [REM_W-1:0] diff_t;
  slot_idx_t        rem_t;

  always_comb begin
    qp     = prod_p[PP_W-1:RP_SHIFT];
    qp_mul = KEY_W'(qp) * KEY_W'(HASH_PRIME);
    diff_p = KEY_W'(key) - qp_mul;
    qt     = prod_t[PT_W-1:RT_SHIFT];
    qt_mul = REM_W'(qt) * REM_W'(SLOT_COUNT);
    diff_t = rem_p - qt_mul;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], req.start};
      done <= vld[3];
    end
    if (req.start) begin
      key <= req.key;
    end
    if (vld[0]) begin
      prod_p <= PP_W'(key) * PP_W'(RECIP_P_V);
    end
    if (vld[1]) begin
      rem_p <= diff_p[REM_W-1:0];
    end
    if (vld[2]) begin
      prod_t <= PT_W'(rem_p) * PT_W'(RECIP_T_V);
    end
    if (vld[3]) begin
      rem_t <= diff_t[SLOT_BITS-1:0];
    end
  end

  assign rsp.done     = done;
  assign rsp.rem      = rem_p;
  assign rsp.slot_rem = rem_t;

endmodule

// ===== sv/two_hash_probing_id_table.sv =====
// From accept to out_valid: the remainder unit reduces the key, the reads start, each
// probe round reads and evaluates both hash slots, and the result is committed. An
// insert that finds neither its ID nor a free slot first runs a second probe for one.
// One transaction at a time: in_ready rises with out_valid, so a new item is taken only
// once the last is committed, later while its result waits for the previous one to be taken.
// Reset: synchronous; then a clearing pass over all SLOT_COUNT slots with in_ready low.
module two_hash_probing_id_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [thp_pkg::ID_W-1:0] id,
  output logic                     out_valid,
  input  logic                     out_ready,
  output thp_pkg::status_t         status,
  output logic [thp_pkg::SLOT_FIELD_W-1:0] slot
);
  import thp_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DIV1 = 4'd2;
  localparam logic [3:0] S_P1   = 4'd4;
  localparam logic [3:0] S_P2   = 4'd5;
  localparam logic [3:0] S_EV   = 4'd6;
  localparam logic [3:0] S_SKIP = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  localparam int ENTRY_W = $bits(entry_t);

  logic [3:0]            state;
  logic                  kind_q;
  logic [ID_W-1:0]       id_q;
  logic [REM_W-1:0]      r;        // key mod prime
  slot_idx_t             rs;       // that, mod slot count
  logic [ROUND_BITS-1:0] rnd;
  logic                  second;
  logic                  have_free;
  slot_idx_t             free_slot;
  entry_t                e1;
  slot_idx_t             ph1;
  slot_idx_t             ph2;
  slot_idx_t             clr_idx;
  status_t               res_status;
  slot_idx_t             res_slot;
  logic                  wr_en;
  entry_t                wr_entry;

  rem_req_t              rreq;
  rem_rsp_t              rrsp;

  logic                  ram_we;
  slot_idx_t             ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic                  ram_re;
  slot_idx_t             ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;

  slot_idx_t             h1;
  slot_idx_t             h2;
  entry_t                e2;
  logic [REM_W-1:0]      r_next;
  slot_idx_t             rs_next;
  logic                  m1;
  logic                  m2;
  logic                  cand_ok;
  slot_idx_t             cand;
  logic                  nf_have;
  slot_idx_t             nf_slot;
  slot_idx_t             hit;
  logic                  hit_act;
  logic                  last;
  logic                  accept;
  logic                  fin_go;
  logic [SLOT_EXT_W-1:0] slot_ext;

  thp_rem u_rem (
    .clk (clk),
    .rst (rst),
    .req (rreq),
    .rsp (rrsp)
  );

  thp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fin_go   = !out_valid || out_ready;

  assign h1 = HASH_ONE_TAB[rs];
  assign h2 = HASH_TWO_TAB[rs];
  assign e2 = entry_t'(ram_rdata);

  // next probe key: reduced forms tracked incrementally
  always_comb begin
    if (r == REM_W'(HASH_PRIME - 1)) begin
      r_next  = '0;
      rs_next = '0;
    end else begin
      r_next  = r + 1'b1;
      rs_next = (rs == SLOT_BITS'(SLOT_COUNT - 1)) ? '0 : rs + 1'b1;
    end
  end

  always_comb begin
    m1      = (e1.id == id_q);
    m2      = (e2.id == id_q);
    cand_ok = !e1.active || !e2.active;
    cand    = !e1.active ? ph1 : ph2;
    nf_have = have_free || cand_ok;
    nf_slot = have_free ? free_slot : cand;
    hit     = m1 ? ph1 : ph2;
    hit_act = m1 ? e1.active : e2.active;
    last    = (rnd == ROUND_BITS'(PROBE_ROUNDS - 1));
  end

  always_comb begin
    rreq.start = accept;
    rreq.key   = id;
  end

  always_comb begin
    ram_re    = (state == S_P1) || (state == S_P2) || (state == S_EV);
    ram_raddr = (state == S_P2) ? h2 : h1;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else begin
      ram_we    = (state == S_FIN) && wr_en && fin_go;
      ram_waddr = res_slot;
      ram_wdata = wr_entry;
    end
  end

  assign slot_ext = SLOT_EXT_W'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == SLOT_BITS'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q    <= kind;
            id_q      <= id;
            rnd       <= '0;
            second    <= 1'b0;
            have_free <= 1'b0;
            free_slot <= '0;
            state     <= S_DIV1;
          end
        end
        S_DIV1: begin
          if (rrsp.done) begin
            r     <= rrsp.rem;
            rs    <= rrsp.slot_rem;
            state <= S_P1;
          end
        end
        S_P1: begin
          state <= S_P2;
        end
        S_P2: begin
          e1    <= entry_t'(ram_rdata);
          ph1   <= h1;
          ph2   <= h2;
          r     <= r_next;
          rs    <= rs_next;
          state <= S_EV;
        end
        S_EV: begin
          if (second) begin
            if (cand_ok) begin
              res_status <= ST_NEW;
              res_slot   <= cand;
              wr_en      <= 1'b1;
              wr_entry   <= '{active: 1'b1, id: id_q};
              state      <= S_FIN;
            end else if (last) begin
              res_status <= ST_FULL;
              res_slot   <= '0;
              wr_en      <= 1'b0;
              state      <= S_FIN;
            end else begin
              rnd   <= rnd + 1'b1;
              state <= S_P2;
            end
          end else if (m1 || m2) begin
            res_slot <= hit;
            wr_entry <= '{active: (kind_q == KIND_INSERT), id: id_q};
            state    <= S_FIN;
            if (kind_q == KIND_REMOVE) begin
              res_status <= ST_REMOVED;
              wr_en      <= 1'b1;
            end else if (hit_act) begin
              res_status <= ST_ACTIVE;
              wr_en      <= 1'b0;
            end else begin
              res_status <= ST_REACTIVATED;
              wr_en      <= 1'b1;
            end
          end else if (last) begin
            if (kind_q == KIND_REMOVE) begin
              res_status <= ST_NOT_FOUND;
              res_slot   <= '0;
              wr_en      <= 1'b0;
              state      <= S_FIN;
            end else if (nf_have) begin
              res_status <= ST_NEW;
              res_slot   <= nf_slot;
              wr_en      <= 1'b1;
              wr_entry   <= '{active: 1'b1, id: id_q};
              state      <= S_FIN;
            end else begin
              // overflow probe starts two keys past the last key searched
              second <= 1'b1;
              rnd    <= '0;
              state  <= S_SKIP;
            end
          end else begin
            have_free <= nf_have;
            free_slot <= nf_slot;
            rnd       <= rnd + 1'b1;
            state     <= S_P2;
          end
        end
        S_SKIP: begin
          r     <= r_next;
          rs    <= rs_next;
          state <= S_P1;
        end
        S_FIN: begin
          if (fin_go) begin
            status <= res_status;
            slot   <= slot_ext[SLOT_FIELD_W-1:0];
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/thp_checker.sv =====
`include "two_hash_probing_id_table_macros.svh"

module thp_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     kind,
  input logic [thp_pkg::ID_W-1:0] id,
  input logic                     out_valid,
  input logic                     out_ready,
  input thp_pkg::status_t         status,
  input logic [thp_pkg::SLOT_FIELD_W-1:0] slot
);
  import thp_pkg::*;

  `THP_ASSERT_IMPL(a_status_legal, out_valid, status == ST_NEW || status == ST_REACTIVATED || status == ST_ACTIVE || status == ST_FULL || status == ST_REMOVED || status == ST_NOT_FOUND, "status code out of range")

  `THP_ASSERT_IMPL(a_no_slot, out_valid && (status == ST_FULL || status == ST_NOT_FOUND), slot == '0, "slot must be zero when none applies")

  `THP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "accepted a second transaction while busy")

  `THP_ASSERT_IMPL(a_clear_after_reset, $fell(rst), !in_ready, "ready during clearing pass")

  `THP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(slot), "stalled result changed")

endmodule

bind two_hash_probing_id_table thp_checker u_thp_checker (.*);

// ===== tb/tb_two_hash_probing_id_table.sv =====
module tb_two_hash_probing_id_table;
  import thp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 92;
  localparam int PHASES         = 8;
  localparam int DIR_ROWS       = 20;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
  } table_result_t;

  typedef struct packed {
    logic                    kind;
    logic [ID_W-1:0]         id;
    logic                    typed;
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot;
  } op_row_t;

  // typed rows: fresh table, ID 0 hits the reset entries at slot 198 (h1 of key 0)
  localparam op_row_t DIR_TABLE [DIR_ROWS] = '{
    '{KIND_REMOVE, 31'd5,          1'b1, ST_NOT_FOUND,   8'd0},
    '{KIND_INSERT, 31'd0,          1'b1, ST_REACTIVATED, 8'd198},
    '{KIND_INSERT, 31'd0,          1'b1, ST_ACTIVE,      8'd198},
    '{KIND_REMOVE, 31'd0,          1'b1, ST_REMOVED,     8'd198},
    '{KIND_REMOVE, 31'd0,          1'b1, ST_REMOVED,     8'd198},
    '{KIND_INSERT, 31'd0,          1'b1, ST_REACTIVATED, 8'd198},
    '{KIND_INSERT, 31'h7FFFFFFF,   1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'h7FFFFFFF,   1'b0, ST_NEW,         8'd0},
    '{KIND_REMOVE, 31'h7FFFFFFF,   1'b0, ST_NEW,         8'd0},
    '{KIND_REMOVE, 31'h7FFFFFFF,   1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'h7FFFFFFF,   1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'd1,          1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'd2,          1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'd3,          1'b0, ST_NEW,         8'd0},
    '{KIND_REMOVE, 31'd2,          1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'd2,          1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'h40000000,   1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'h2AAAAAAA,   1'b0, ST_NEW,         8'd0},
    '{KIND_INSERT, 31'h55555555,   1'b0, ST_NEW,         8'd0},
    '{KIND_REMOVE, 31'h12345678,   1'b1, ST_NOT_FOUND,   8'd0}
  };

  localparam idle_mode_t PHASE_MODE [PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                                 IDLE_NONE, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
  localparam int INSERT_PCT [PHASES] = '{80, 80, 85, 85, 95, 95, 40, 30};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    kind = KIND_INSERT;
  logic [ID_W-1:0]         id = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  status_t                 status;
  logic [SLOT_FIELD_W-1:0] slot;

  table_result_t    pending_results[$];
  logic [KEY_W-1:0] tab_id[SLOT_COUNT];
  logic             tab_live[SLOT_COUNT];
  logic [ID_W-1:0]  seen_ids[$];
  int               fails = 0;
  idle_mode_t       idle_mode = IDLE_NONE;
  bit               hold_go = 1'b0;
  int               hold_left = 0;
  int               quiet_cycles = 0;

  two_hash_probing_id_table u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .id        (id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .slot      (slot)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned hash_slot(logic [KEY_W-1:0] key, int unsigned mul,
                                            int unsigned add);
    longint unsigned v;
    v = key;
    v = (v % HASH_PRIME) % SLOT_COUNT;
    v = (v * mul + add) % HASH_PRIME;
    return int'(v % SLOT_COUNT);
  endfunction

  // applies one operation to the shadow table and returns its result
  function automatic table_result_t apply_table_op(logic op, logic [ID_W-1:0] acct);
    logic [KEY_W-1:0] want;
    logic [KEY_W-1:0] key;
    int unsigned      h1, h2, hit, free_slot;
    bit               found, have_free;
    want = KEY_W'(acct);
    key = want;
    found = 1'b0;
    have_free = 1'b0;
    hit = 0;
    free_slot = 0;
    for (int r = 0; r < PROBE_ROUNDS && !found; r++) begin
      h1 = hash_slot(key, HASH_MUL_ONE, HASH_MUL_TWO);
      h2 = hash_slot(key, HASH_MUL_TWO, HASH_MUL_ONE);
      if (!have_free) begin
        if (!tab_live[h1]) begin
          have_free = 1'b1;
          free_slot = h1;
        end else if (!tab_live[h2]) begin
          have_free = 1'b1;
          free_slot = h2;
        end
      end
      // stored ID matches regardless of the active flag
      if (tab_id[h1] == want) begin
        found = 1'b1;
        hit = h1;
      end else if (tab_id[h2] == want) begin
        found = 1'b1;
        hit = h2;
      end
      key = key + 1;
    end
    if (op == KIND_REMOVE) begin
      if (!found) return '{ST_NOT_FOUND, '0};
      tab_live[hit] = 1'b0;
      return '{ST_REMOVED, SLOT_FIELD_W'(hit)};
    end
    if (found) begin
      if (tab_live[hit]) return '{ST_ACTIVE, SLOT_FIELD_W'(hit)};
      tab_live[hit] = 1'b1;
      return '{ST_REACTIVATED, SLOT_FIELD_W'(hit)};
    end
    // second probe starts two keys past the last key of the first
    key = want + PROBE_ROUNDS + 1;
    for (int r = 0; r < PROBE_ROUNDS && !have_free; r++) begin
      h1 = hash_slot(key, HASH_MUL_ONE, HASH_MUL_TWO);
      h2 = hash_slot(key, HASH_MUL_TWO, HASH_MUL_ONE);
      if (!tab_live[h1]) begin
        have_free = 1'b1;
        free_slot = h1;
      end else if (!tab_live[h2]) begin
        have_free = 1'b1;
        free_slot = h2;
      end
      key = key + 1;
    end
    if (!have_free) return '{ST_FULL, '0};
    tab_id[free_slot] = want;
    tab_live[free_slot] = 1'b1;
    return '{ST_NEW, SLOT_FIELD_W'(free_slot)};
  endfunction

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got_v, want_v);
    fails++;
  endtask

  // offers one transaction, waits for its acceptance, then records the expected result
  task automatic offer(logic op, logic [ID_W-1:0] acct, logic typed, table_result_t typed_res);
    table_result_t predicted;
    int            gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 48 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= op;
    id <= acct;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_table_op(op, acct);
    pending_results.push_back(typed ? typed_res : predicted);
    if (op == KIND_INSERT) begin
      seen_ids.push_back(acct);
      if (seen_ids.size() > 400) void'(seen_ids.pop_front());
    end
  endtask

  always @(posedge clk) begin
    table_result_t got, want;
    int            stall_pct;
    if (!rst && out_valid && out_ready) begin
      got = '{status, slot};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", got.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) report_mismatch("status", got.status, want.status);
        if (got.slot != want.slot) report_mismatch("slot", got.slot, want.slot);
      end
    end
    stall_pct = (idle_mode == IDLE_RECV) ? 48 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               sel;
    logic             op;
    logic [ID_W-1:0]  acct;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tab_id[i] = '0;
      tab_live[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      offer(DIR_TABLE[i].kind, DIR_TABLE[i].id, DIR_TABLE[i].typed,
            '{DIR_TABLE[i].status, DIR_TABLE[i].slot});

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_mode = PHASE_MODE[ph];
      // long output stall while inputs keep coming; block backs up into in_ready
      if (ph == 4) hold_go = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < INSERT_PCT[ph]) ? KIND_INSERT : KIND_REMOVE;
        sel = $urandom_range(99);
        if (sel < 40 && seen_ids.size() > 0) begin
          acct = seen_ids[$urandom_range(seen_ids.size() - 1)];
        end else if (sel < 70) begin
          // dense low range: neighboring IDs share probe keys
          acct = ID_W'($urandom_range(511));
        end else if (sel < 90) begin
          acct = ID_W'($urandom);
        end else begin
          case ($urandom_range(3))
            0:       acct = '0;
            1:       acct = '1;
            2:       acct = ~ID_W'($urandom_range(40));
            default: acct = ID_W'(1) << $urandom_range(ID_W - 1);
          endcase
        end
        offer(op, acct, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    idle_mode = IDLE_NONE;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/thp_pkg.sv
sv/thp_ram.sv
sv/thp_rem.sv
sv/two_hash_probing_id_table.sv
sv/thp_checker.sv
tb/tb_two_hash_probing_id_table.sv
